// ===== sv/can_mailbox_manager_rx_queue_unit_macros.svh =====
// -----------------------------------------------------------------------------
// CAN mailbox manager macros
// Assertion shorthands shared by the mailbox manager modules.
// -----------------------------------------------------------------------------
`ifndef CAN_MAILBOX_MANAGER_RX_QUEUE_UNIT_MACROS_SVH
`define CAN_MAILBOX_MANAGER_RX_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CMRQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CMRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cmrq_pkg.sv =====
// -----------------------------------------------------------------------------
// CAN mailbox manager package
// Types, codes and defaults shared by the mailbox manager modules.
// -----------------------------------------------------------------------------
package cmrq_pkg;

	localparam int MAILBOXES_DEF         = 15;
	localparam int RECEIVE_MAILBOXES_DEF = 10;
	localparam int QUEUE_DEPTH_DEF       = 64;

	localparam int NUM_COUNTERS = 10;
	localparam int CNT_AW       = 4;
	localparam int CNT_W        = 16;

	typedef logic [CNT_AW-1:0] cnt_addr_t;

	localparam cnt_addr_t CNT_DLCW  = 4'd0;
	localparam cnt_addr_t CNT_RX    = 4'd1;
	localparam cnt_addr_t CNT_TX    = 4'd2;
	localparam cnt_addr_t CNT_ACK   = 4'd3;
	localparam cnt_addr_t CNT_FORM  = 4'd4;
	localparam cnt_addr_t CNT_CRC   = 4'd5;
	localparam cnt_addr_t CNT_STUFF = 4'd6;
	localparam cnt_addr_t CNT_BIT   = 4'd7;
	localparam cnt_addr_t CNT_NOMB  = 4'd8;
	localparam cnt_addr_t CNT_ALLOC = 4'd9;
	localparam cnt_addr_t CNT_SUM   = 4'd10;

	// Error total covers the length warning plus ack through overflow.
	localparam int SUM_READS = 1 + NUM_COUNTERS - 3;

	localparam logic [7:0] ST_RX_WARN = 8'hA0;
	localparam logic [7:0] ST_RX_OK   = 8'h20;
	localparam logic [7:0] ST_TX_OK   = 8'h40;
	localparam logic [7:0] ST_ACK     = 8'h01;
	localparam logic [7:0] ST_FORM    = 8'h02;
	localparam logic [7:0] ST_CRC     = 8'h04;
	localparam logic [7:0] ST_STUFF   = 8'h08;
	localparam logic [7:0] ST_BIT     = 8'h10;

	typedef enum logic [1:0] {
		MODE_TX_REQ,
		MODE_EVENT,
		MODE_READ,
		MODE_QUERY
	} mode_t;

	typedef enum logic [2:0] {
		RES_OK,
		RES_NO_MAILBOX,
		RES_QUEUE_FULL,
		RES_IGNORED,
		RES_QUEUE_EMPTY
	} res_code_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RECV,
		S_PUSH,
		S_POP,
		S_QUERY,
		S_SUM,
		S_CNT_RD,
		S_CNT_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             rd_en;
		cnt_addr_t        rd_addr;
		logic             wr_en;
		cnt_addr_t        wr_addr;
		logic [CNT_W-1:0] wr_data;
	} cnt_req_t;

	typedef struct packed {
		logic       push;
		logic [7:0] push_data;
		logic       pop;
	} q_req_t;

endpackage

// ===== sv/cmrq_counters.sv =====
// -----------------------------------------------------------------------------
// CAN mailbox manager event counters
// Counter memory with registered read, write forwarding and per-entry valid
// bits so that entries read as zero until first written after reset.
// -----------------------------------------------------------------------------
`include "can_mailbox_manager_rx_queue_unit_macros.svh"

module cmrq_counters
	import cmrq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cnt_req_t         req,
	output logic [CNT_W-1:0] rd_data
);

	logic [CNT_W-1:0]        mem [NUM_COUNTERS];
	logic [NUM_COUNTERS-1:0] valid_q;
	logic [CNT_W-1:0]        rd_raw_q;
	logic                    rd_hit_q;
	logic                    fwd;

	assign fwd = req.wr_en && (req.wr_addr == req.rd_addr);

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_raw_q <= fwd ? req.wr_data : mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_hit_q <= fwd || valid_q[req.rd_addr];
			end
		end
	end

	// Never-written counters read as zero
	assign rd_data = rd_hit_q ? rd_raw_q : '0;

	`CMRQ_ASSERT_NOW(a_cnt_wr_range, req.wr_en, req.wr_addr < cnt_addr_t'(NUM_COUNTERS), "counter write beyond last counter")
	`CMRQ_ASSERT_NOW(a_cnt_rd_range, req.rd_en, req.rd_addr < cnt_addr_t'(NUM_COUNTERS), "counter read beyond last counter")

endmodule

// ===== sv/cmrq_queue.sv =====
// -----------------------------------------------------------------------------
// CAN mailbox manager receive byte queue
// Circular byte memory with head, tail and fill count; one push or one pop
// per cycle, pop data registered and shown in the cycle after the request.
// -----------------------------------------------------------------------------
`include "can_mailbox_manager_rx_queue_unit_macros.svh"

module cmrq_queue
	import cmrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  q_req_t                         req,
	output logic [$clog2(QUEUE_DEPTH)-1:0] fill,
	output logic                           rd_valid,
	output logic [7:0]                     rd_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

	logic [7:0]    mem [QUEUE_DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] fill_q;
	logic          rd_valid_q;
	logic [7:0]    rd_data_q;
	logic          pop_go;

	// Drop pops on an empty queue; the missing byte reads as zero upstream
	assign pop_go = req.pop && (fill_q != '0);

	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[tail_q] <= req.push_data;
		end
		if (pop_go) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			fill_q     <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= pop_go;
			if (req.push) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + 1'b1;
				fill_q <= fill_q + 1'b1;
			end else if (pop_go) begin
				head_q <= (head_q == LAST) ? '0 : head_q + 1'b1;
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign fill     = fill_q;
	assign rd_valid = rd_valid_q;
	assign rd_data  = rd_data_q;

	`CMRQ_ASSERT_NOW(a_q_no_push_pop, req.push, !req.pop, "queue push and pop in the same cycle")
	`CMRQ_ASSERT_NOW(a_q_fill_bound, 1'b1, fill_q <= LAST, "queue fill beyond capacity")
	`CMRQ_ASSERT_NOW(a_q_push_room, req.push, fill_q != LAST, "queue push while full")

endmodule

// ===== sv/can_mailbox_manager_rx_queue_unit.sv =====
// -----------------------------------------------------------------------------
// CAN mailbox manager with receive queue
// Mailbox allocation, receive byte queue and event counters behind a
// start/busy command port with a one-cycle done strobe.
// -----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the result is shown for exactly one cycle with done, and it drops in the
// cycle after, so the receiver must take the beat when done is high. A
// granted transmit request or an ignored event goes from decode to done, a
// counted event first reads and writes its counter, a received frame pushes
// its header and payload before counting, a frame read pops them back, and
// the error total reads the counters in turn. The single port of the queue
// memory, one byte per cycle, and the counter read-then-write set these steps.
// -----------------------------------------------------------------------------
`include "can_mailbox_manager_rx_queue_unit_macros.svh"

module can_mailbox_manager_rx_queue_unit
	import cmrq_pkg::*;
#(
	parameter int MAILBOXES         = MAILBOXES_DEF,
	parameter int RECEIVE_MAILBOXES = RECEIVE_MAILBOXES_DEF,
	parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [3:0]  mailbox_num,
	input  logic [7:0]  event_status,
	input  logic [10:0] frame_id,
	input  logic [3:0]  frame_len,
	input  logic        subscribed,
	input  logic [63:0] rx_payload,
	input  logic [3:0]  counter_select,
	output logic        done,
	output logic [2:0]  result_code,
	output logic [3:0]  granted_mailbox,
	output logic [15:0] out_id,
	output logic [7:0]  out_len,
	output logic [63:0] out_payload,
	output logic [15:0] counter_value
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam logic [MAILBOXES-1:0] BUSY_RESET = MAILBOXES'(
		((1 << MAILBOXES) - 1) - ((1 << (MAILBOXES - RECEIVE_MAILBOXES)) - 1));

	state_t              state_q, state_d;
	state_t              after_q, after_d;
	cnt_addr_t           bump_q, bump_d;
	logic [MAILBOXES-1:0] busy_mask_q;
	logic [3:0]          idx_q;
	logic                cnt_rd_s1;
	logic [3:0]          rd_idx_s1;

	mode_t               mode_q;
	logic [3:0]          mailbox_q;
	logic [7:0]          status_q;
	logic [10:0]         fid_q;
	logic [3:0]          flen_q;
	logic                sub_q;
	logic [63:0]         pay_q;
	cnt_addr_t           sel_q;

	res_code_t           res_code_q;
	logic [3:0]          res_mb_q;
	logic [15:0]         res_id_q;
	logic [7:0]          res_len_q;
	logic [63:0]         res_pay_q;
	logic [CNT_W-1:0]    res_cnt_q;

	cnt_req_t            cnt_req;
	logic [CNT_W-1:0]    cnt_rd_data;
	q_req_t              q_req;
	logic [QAW-1:0]      q_fill;
	logic                q_rd_valid;
	logic [7:0]          q_rd_data;

	logic                free_found;
	logic [3:0]          free_idx;
	logic                space_ok;
	logic [7:0]          push_byte;
	logic [3:0]          push_last;
	logic [7:0]          len_cur;
	logic [3:0]          pop_need;
	logic                pop_slot;
	cnt_addr_t           sum_addr;

	cmrq_counters u_counters (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cnt_req),
		.rd_data (cnt_rd_data)
	);

	cmrq_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (q_req),
		.fill     (q_fill),
		.rd_valid (q_rd_valid),
		.rd_data  (q_rd_data)
	);

	// Lowest free mailbox
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = MAILBOXES - 1; i >= 0; i--) begin
			if (!busy_mask_q[i]) begin
				free_found = 1'b1;
				free_idx   = 4'(i);
			end
		end
	end

	// Push needs free space above header plus payload
	assign space_ok = ({1'b0, q_fill} + (QAW+1)'(flen_q) + (QAW+1)'(4))
		< (QAW+1)'(QUEUE_DEPTH);

	assign push_last = 4'd2 + flen_q;

	always_comb begin
		unique case (idx_q)
			4'd0:    push_byte = {5'd0, fid_q[10:8]};
			4'd1:    push_byte = fid_q[7:0];
			4'd2:    push_byte = {4'd0, flen_q};
			default: push_byte = pay_q[8*(3'(idx_q - 4'd3)) +: 8];
		endcase
	end

	// Length byte is known from the cycle it comes back from the queue
	assign len_cur  = (q_rd_valid && rd_idx_s1 == 4'd2) ? q_rd_data : res_len_q;
	assign pop_need = 4'd3 + ((len_cur > 8'd8) ? 4'd8 : len_cur[3:0]);
	assign pop_slot = (idx_q < 4'd3) || (idx_q < pop_need);

	assign sum_addr = (idx_q == 4'd0) ? CNT_DLCW : cnt_addr_t'(idx_q + 4'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		after_d = after_q;
		bump_d  = bump_q;
		cnt_req = '0;
		q_req   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				after_d = S_DONE;
				unique case (mode_q)
					MODE_TX_REQ: begin
						bump_d  = CNT_NOMB;
						state_d = free_found ? S_DONE : S_CNT_RD;
					end
					MODE_EVENT: begin
						unique case (status_q)
							ST_RX_WARN: begin
								bump_d  = CNT_DLCW;
								after_d = S_RECV;
								state_d = S_CNT_RD;
							end
							ST_RX_OK: state_d = S_RECV;
							ST_TX_OK: begin
								bump_d  = CNT_TX;
								state_d = S_CNT_RD;
							end
							ST_ACK: begin
								bump_d  = CNT_ACK;
								state_d = S_CNT_RD;
							end
							ST_FORM: begin
								bump_d  = CNT_FORM;
								state_d = S_CNT_RD;
							end
							ST_CRC: begin
								bump_d  = CNT_CRC;
								state_d = S_CNT_RD;
							end
							ST_STUFF: begin
								bump_d  = CNT_STUFF;
								state_d = S_CNT_RD;
							end
							ST_BIT: begin
								bump_d  = CNT_BIT;
								state_d = S_CNT_RD;
							end
							default: state_d = S_DONE;
						endcase
					end
					MODE_READ: begin
						state_d = (q_fill == '0) ? S_DONE : S_POP;
					end
					MODE_QUERY: begin
						if (sel_q < cnt_addr_t'(NUM_COUNTERS)) begin
							cnt_req.rd_en   = 1'b1;
							cnt_req.rd_addr = sel_q;
							state_d         = S_QUERY;
						end else if (sel_q == CNT_SUM) begin
							state_d = S_SUM;
						end else begin
							state_d = S_DONE;
						end
					end
				endcase
			end
			S_RECV: begin
				after_d = S_DONE;
				if (!sub_q) begin
					state_d = S_DONE;
				end else if (space_ok) begin
					state_d = S_PUSH;
				end else begin
					bump_d  = CNT_ALLOC;
					state_d = S_CNT_RD;
				end
			end
			S_PUSH: begin
				q_req.push      = 1'b1;
				q_req.push_data = push_byte;
				if (idx_q == push_last) begin
					bump_d  = CNT_RX;
					after_d = S_DONE;
					state_d = S_CNT_RD;
				end
			end
			S_POP: begin
				q_req.pop = pop_slot;
				if (!pop_slot && !q_rd_valid) begin
					state_d = S_DONE;
				end
			end
			S_QUERY: state_d = S_DONE;
			S_SUM: begin
				if (idx_q < 4'(SUM_READS)) begin
					cnt_req.rd_en   = 1'b1;
					cnt_req.rd_addr = sum_addr;
				end else if (!cnt_rd_s1) begin
					state_d = S_DONE;
				end
			end
			S_CNT_RD: begin
				cnt_req.rd_en   = 1'b1;
				cnt_req.rd_addr = bump_q;
				state_d         = S_CNT_WR;
			end
			S_CNT_WR: begin
				cnt_req.wr_en   = 1'b1;
				cnt_req.wr_addr = bump_q;
				cnt_req.wr_data = cnt_rd_data + 1'b1;
				state_d         = after_q;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_q     <= S_DONE;
			bump_q      <= CNT_DLCW;
			busy_mask_q <= BUSY_RESET;
			idx_q       <= '0;
			cnt_rd_s1   <= 1'b0;
		end else begin
			after_q   <= after_d;
			bump_q    <= bump_d;
			cnt_rd_s1 <= cnt_req.rd_en;
			unique case (state_q)
				S_IDLE: idx_q <= '0;
				S_DECODE: begin
					for (int i = 0; i < MAILBOXES; i++) begin
						if (mode_q == MODE_TX_REQ && free_found && free_idx == 4'(i)) begin
							busy_mask_q[i] <= 1'b1;
						end
						if (mode_q == MODE_EVENT && status_q == ST_TX_OK
								&& mailbox_q == 4'(i)) begin
							busy_mask_q[i] <= 1'b0;
						end
					end
				end
				S_PUSH: idx_q <= idx_q + 1'b1;
				S_POP: begin
					if (pop_slot) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SUM: begin
					if (idx_q < 4'(SUM_READS)) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					mode_q     <= mode_t'(mode);
					mailbox_q  <= mailbox_num;
					status_q   <= event_status;
					fid_q      <= frame_id;
					flen_q     <= (frame_len > 4'd8) ? 4'd8 : frame_len;
					sub_q      <= subscribed;
					pay_q      <= rx_payload;
					sel_q      <= counter_select;
					res_code_q <= RES_OK;
					res_mb_q   <= '0;
					res_id_q   <= '0;
					res_len_q  <= '0;
					res_pay_q  <= '0;
					res_cnt_q  <= '0;
				end
			end
			S_DECODE: begin
				unique case (mode_q)
					MODE_TX_REQ: begin
						if (free_found) begin
							res_mb_q <= free_idx;
						end else begin
							res_code_q <= RES_NO_MAILBOX;
						end
					end
					MODE_EVENT: begin
						if (status_q != ST_RX_WARN && status_q != ST_RX_OK
								&& status_q != ST_TX_OK && status_q != ST_ACK
								&& status_q != ST_FORM && status_q != ST_CRC
								&& status_q != ST_STUFF && status_q != ST_BIT) begin
							res_code_q <= RES_IGNORED;
						end
					end
					MODE_READ: begin
						if (q_fill == '0) begin
							res_code_q <= RES_QUEUE_EMPTY;
						end
					end
					MODE_QUERY: begin
						if (sel_q > CNT_SUM) begin
							res_code_q <= RES_IGNORED;
						end
					end
				endcase
			end
			S_RECV: begin
				if (!sub_q) begin
					res_code_q <= RES_IGNORED;
				end else if (!space_ok) begin
					res_code_q <= RES_QUEUE_FULL;
				end
			end
			S_POP: begin
				rd_idx_s1 <= idx_q;
				if (q_rd_valid) begin
					unique case (rd_idx_s1)
						4'd0:    res_id_q[15:8] <= q_rd_data;
						4'd1:    res_id_q[7:0]  <= q_rd_data;
						4'd2:    res_len_q      <= q_rd_data;
						default: res_pay_q[8*(3'(rd_idx_s1 - 4'd3)) +: 8] <= q_rd_data;
					endcase
				end
			end
			S_QUERY: res_cnt_q <= cnt_rd_data;
			S_SUM: begin
				if (cnt_rd_s1) begin
					res_cnt_q <= res_cnt_q + cnt_rd_data;
				end
			end
			default: ;
		endcase
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = (state_q == S_DONE);
	assign result_code     = res_code_q;
	assign granted_mailbox = res_mb_q;
	assign out_id          = res_id_q;
	assign out_len         = res_len_q;
	assign out_payload     = res_pay_q;
	assign counter_value   = res_cnt_q;

	`CMRQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted beat not held busy")
	`CMRQ_ASSERT_NEXT(a_done_release, done, !busy, "busy held after result beat")
	`CMRQ_ASSERT_NOW(a_pop_on_read, q_req.pop, mode_q == MODE_READ, "queue pop outside a frame read")
	`CMRQ_ASSERT_NOW(a_push_subscribed, q_req.push, sub_q && mode_q == MODE_EVENT, "queue push for unwanted frame")

endmodule

// ===== tb/sv/can_mailbox_manager_rx_queue_unit_checker.sv =====
// -----------------------------------------------------------------------------
// CAN mailbox manager result checker
// Watches the command and result ports, keeps its own copy of the mailbox
// mask, receive byte queue and event counters, and compares every result
// beat with the oldest predicted one.
// -----------------------------------------------------------------------------
module can_mailbox_manager_rx_queue_unit_checker
	import cmrq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  mode,
	input  logic [3:0]  mailbox_num,
	input  logic [7:0]  event_status,
	input  logic [10:0] frame_id,
	input  logic [3:0]  frame_len,
	input  logic        subscribed,
	input  logic [63:0] rx_payload,
	input  logic [3:0]  counter_select,
	input  logic        done,
	input  logic [2:0]  result_code,
	input  logic [3:0]  granted_mailbox,
	input  logic [15:0] out_id,
	input  logic [7:0]  out_len,
	input  logic [63:0] out_payload,
	input  logic [15:0] counter_value,
	input  logic        wrap_up,
	output int          mismatches,
	output int          outstanding
);

	localparam int PRINT_CAP = 40;

	typedef struct packed {
		res_code_t   code;
		logic [3:0]  grant;
		logic [15:0] id;
		logic [7:0]  len;
		logic [63:0] pay;
		logic [15:0] cval;
	} reply_t;

	logic [MAILBOXES_DEF-1:0] mbox_busy;
	logic [7:0]  rxq_mem [QUEUE_DEPTH_DEF];
	int          rxq_rd;
	int          rxq_wr;
	int          rxq_count;
	logic [15:0] evt_count [NUM_COUNTERS];
	reply_t      replies_due [$];

	int results_seen = 0;
	int peak_fill = 0;
	int op_hits [4] = '{default: 0};
	int code_hits [5] = '{default: 0};
	bit wrapped = 1'b0;

	initial mismatches = 0;
	initial outstanding = 0;

	task automatic log_mismatch(string what);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %0h want %0h (result beat %0d)",
				name, got, want, results_seen));
	endtask

	function automatic void bump(cnt_addr_t k);
		evt_count[k] = evt_count[k] + 16'd1;
	endfunction

	function automatic void rxq_push(logic [7:0] b);
		rxq_mem[rxq_wr] = b;
		rxq_wr = (rxq_wr + 1) % QUEUE_DEPTH_DEF;
		rxq_count++;
	endfunction

	function automatic logic [7:0] rxq_pop();
		logic [7:0] b;
		if (rxq_count == 0)
			return 8'd0;
		b = rxq_mem[rxq_rd];
		rxq_rd = (rxq_rd + 1) % QUEUE_DEPTH_DEF;
		rxq_count--;
		return b;
	endfunction

	function automatic reply_t predict_reply(mode_t op, logic [3:0] mb, logic [7:0] st,
			logic [10:0] id, logic [3:0] len, logic sub, logic [63:0] pay, cnt_addr_t sel);
		reply_t r;
		int i;
		int n;
		int s;
		r = '0;
		r.code = RES_OK;
		case (op)
			MODE_TX_REQ: begin
				// grant the lowest free mailbox
				r.code = RES_NO_MAILBOX;
				for (i = 0; i < MAILBOXES_DEF; i++)
					if (r.code == RES_NO_MAILBOX && !mbox_busy[i]) begin
						mbox_busy[i] = 1'b1;
						r.grant = 4'(i);
						r.code = RES_OK;
					end
				if (r.code == RES_NO_MAILBOX)
					bump(CNT_NOMB);
			end
			MODE_EVENT: begin
				case (st)
					ST_RX_WARN, ST_RX_OK: begin
						if (st == ST_RX_WARN)
							bump(CNT_DLCW);
						n = (len > 4'd8) ? 8 : int'(len);
						if (!sub) begin
							r.code = RES_IGNORED;
						end else if (QUEUE_DEPTH_DEF - 1 - rxq_count > 3 + n) begin
							rxq_push({5'b0, id[10:8]});
							rxq_push(id[7:0]);
							rxq_push(8'(n));
							for (i = 0; i < n; i++)
								rxq_push(pay[8*i +: 8]);
							bump(CNT_RX);
						end else begin
							bump(CNT_ALLOC);
							r.code = RES_QUEUE_FULL;
						end
					end
					ST_TX_OK: begin
						bump(CNT_TX);
						if (mb < MAILBOXES_DEF)
							mbox_busy[mb] = 1'b0;
					end
					ST_ACK:   bump(CNT_ACK);
					ST_FORM:  bump(CNT_FORM);
					ST_CRC:   bump(CNT_CRC);
					ST_STUFF: bump(CNT_STUFF);
					ST_BIT:   bump(CNT_BIT);
					default:  r.code = RES_IGNORED;
				endcase
			end
			MODE_READ: begin
				if (rxq_count == 0) begin
					r.code = RES_QUEUE_EMPTY;
				end else begin
					r.id[15:8] = rxq_pop();
					r.id[7:0] = rxq_pop();
					r.len = rxq_pop();
					n = (r.len > 8'd8) ? 8 : int'(r.len);
					for (i = 0; i < n; i++)
						r.pay[8*i +: 8] = rxq_pop();
				end
			end
			default: begin
				if (sel < NUM_COUNTERS) begin
					r.cval = evt_count[sel];
				end else if (sel == CNT_SUM) begin
					s = evt_count[CNT_DLCW];
					for (i = CNT_ACK; i < NUM_COUNTERS; i++)
						s += evt_count[i];
					r.cval = s[15:0];
				end else begin
					r.code = RES_IGNORED;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		int i;
		if (!arst_n) begin
			for (i = 0; i < MAILBOXES_DEF; i++)
				mbox_busy[i] = (i >= MAILBOXES_DEF - RECEIVE_MAILBOXES_DEF);
			rxq_rd = 0;
			rxq_wr = 0;
			rxq_count = 0;
			for (i = 0; i < NUM_COUNTERS; i++)
				evt_count[i] = 16'd0;
			replies_due.delete();
			outstanding = 0;
		end else begin
			if (done) begin
				results_seen++;
				if (replies_due.size() == 0) begin
					log_mismatch($sformatf("result beat %0d with no command outstanding",
						results_seen));
				end else begin
					want = replies_due.pop_front();
					check_field("result_code", result_code, want.code);
					check_field("granted_mailbox", granted_mailbox, want.grant);
					check_field("out_id", out_id, want.id);
					check_field("out_len", out_len, want.len);
					check_field("out_payload", out_payload, want.pay);
					check_field("counter_value", counter_value, want.cval);
				end
			end
			if (start && !busy) begin
				want = predict_reply(mode_t'(mode), mailbox_num, event_status, frame_id,
					frame_len, subscribed, rx_payload, counter_select);
				replies_due.push_back(want);
				op_hits[mode]++;
				code_hits[want.code]++;
				if (rxq_count > peak_fill)
					peak_fill = rxq_count;
			end
			outstanding = replies_due.size();
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (replies_due.size() != 0)
					log_mismatch($sformatf("%0d results never arrived", replies_due.size()));
				$display("covered %0d commands: %0d tx requests, %0d events, %0d reads, %0d queries",
					results_seen, op_hits[MODE_TX_REQ], op_hits[MODE_EVENT],
					op_hits[MODE_READ], op_hits[MODE_QUERY]);
				$display("results: %0d ok, %0d no mailbox, %0d queue full, %0d ignored, %0d empty; peak queue fill %0d bytes",
					code_hits[RES_OK], code_hits[RES_NO_MAILBOX], code_hits[RES_QUEUE_FULL],
					code_hits[RES_IGNORED], code_hits[RES_QUEUE_EMPTY], peak_fill);
			end
		end
	end

endmodule

// ===== tb/sv/can_mailbox_manager_rx_queue_unit_tb.sv =====
// -----------------------------------------------------------------------------
// CAN mailbox manager testbench
// Drives directed and random commands through the start/busy port with
// varying sender gaps; a checker beside the block predicts and compares.
// -----------------------------------------------------------------------------
module can_mailbox_manager_rx_queue_unit_tb;
	import cmrq_pkg::*;

	localparam int STALL_LIMIT     = 4000;
	localparam int ITEMS_PER_PHASE = 400;
	localparam int TAIL_CYCLES     = 40;

	localparam logic [7:0] ST_UNDEFINED     = 8'hFF;
	localparam cnt_addr_t  SEL_OUT_OF_RANGE = 4'd15;

	typedef struct packed {
		mode_t       op;
		logic [3:0]  mb;
		logic [7:0]  status;
		logic [10:0] id;
		logic [3:0]  len;
		logic        sub;
		logic [63:0] pay;
		cnt_addr_t   sel;
	} cmd_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  mode = '0;
	logic [3:0]  mailbox_num = '0;
	logic [7:0]  event_status = '0;
	logic [10:0] frame_id = '0;
	logic [3:0]  frame_len = '0;
	logic        subscribed = 1'b0;
	logic [63:0] rx_payload = '0;
	logic [3:0]  counter_select = '0;
	logic        wrap_up = 1'b0;

	logic        busy;
	logic        done;
	logic [2:0]  result_code;
	logic [3:0]  granted_mailbox;
	logic [15:0] out_id;
	logic [7:0]  out_len;
	logic [63:0] out_payload;
	logic [15:0] counter_value;

	int fail_count;
	int outstanding;
	int idle_pct = 0;
	int stall_cycles = 0;

	can_mailbox_manager_rx_queue_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .mailbox_num(mailbox_num), .event_status(event_status),
		.frame_id(frame_id), .frame_len(frame_len), .subscribed(subscribed),
		.rx_payload(rx_payload), .counter_select(counter_select),
		.done(done), .result_code(result_code), .granted_mailbox(granted_mailbox),
		.out_id(out_id), .out_len(out_len), .out_payload(out_payload),
		.counter_value(counter_value)
	);

	can_mailbox_manager_rx_queue_unit_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .mailbox_num(mailbox_num), .event_status(event_status),
		.frame_id(frame_id), .frame_len(frame_len), .subscribed(subscribed),
		.rx_payload(rx_payload), .counter_select(counter_select),
		.done(done), .result_code(result_code), .granted_mailbox(granted_mailbox),
		.out_id(out_id), .out_len(out_len), .out_payload(out_payload),
		.counter_value(counter_value),
		.wrap_up(wrap_up), .mismatches(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// end the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic cmd_t random_cmd(int read_pct);
		cmd_t c;
		int pick;
		int k;
		c.mb = 4'($urandom_range(0, 15));
		c.id = 11'($urandom_range(0, 2047));
		c.len = 4'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 15));
		c.sub = ($urandom_range(0, 99) < 85);
		c.pay = {$urandom, $urandom};
		c.sel = cnt_addr_t'($urandom_range(0, 15));
		k = $urandom_range(0, 99);
		if (k < 40)
			c.status = ST_RX_OK;
		else if (k < 50)
			c.status = ST_RX_WARN;
		else if (k < 65)
			c.status = ST_TX_OK;
		else if (k < 88) begin
			case ($urandom_range(0, 4))
				0:       c.status = ST_ACK;
				1:       c.status = ST_FORM;
				2:       c.status = ST_CRC;
				3:       c.status = ST_STUFF;
				default: c.status = ST_BIT;
			endcase
		end else
			c.status = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < read_pct)
			c.op = MODE_READ;
		else if (pick < read_pct + 14)
			c.op = MODE_TX_REQ;
		else if (pick < read_pct + 30)
			c.op = MODE_QUERY;
		else
			c.op = MODE_EVENT;
		return c;
	endfunction

	function automatic cmd_t blank_cmd(mode_t op);
		cmd_t c;
		c = random_cmd(0);
		c.op = op;
		return c;
	endfunction

	function automatic cmd_t rx_frame(logic [7:0] st, logic [10:0] id, logic [3:0] len,
			logic sub, logic [63:0] pay);
		cmd_t c;
		c = blank_cmd(MODE_EVENT);
		c.status = st;
		c.id = id;
		c.len = len;
		c.sub = sub;
		c.pay = pay;
		return c;
	endfunction

	// hold start low for random gaps, then present the beat until it is taken
	task automatic send_cmd(cmd_t c);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode <= c.op;
		mailbox_num <= c.mb;
		event_status <= c.status;
		frame_id <= c.id;
		frame_len <= c.len;
		subscribed <= c.sub;
		rx_payload <= c.pay;
		counter_select <= c.sel;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		cmd_t c;
		int phase;
		int k;
		int read_pct;
		logic [7:0] err_codes [5];
		err_codes = '{ST_ACK, ST_FORM, ST_CRC, ST_STUFF, ST_BIT};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 30;
		send_cmd(blank_cmd(MODE_READ));
		// exhaust the free mailboxes, one request more than there are
		repeat (MAILBOXES_DEF - RECEIVE_MAILBOXES_DEF + 1)
			send_cmd(blank_cmd(MODE_TX_REQ));
		c = blank_cmd(MODE_EVENT);
		c.status = ST_TX_OK;
		c.mb = 4'd15;
		send_cmd(c);
		c.mb = 4'd0;
		send_cmd(c);
		send_cmd(rx_frame(ST_RX_OK, 11'd0, 4'd0, 1'b1, 64'd0));
		send_cmd(rx_frame(ST_RX_WARN, 11'h7FF, 4'd15, 1'b1, '1));
		send_cmd(rx_frame(ST_RX_OK, 11'h555, 4'd8, 1'b0, {$urandom, $urandom}));
		send_cmd(rx_frame(ST_RX_WARN, 11'h2AA, 4'd3, 1'b0, {$urandom, $urandom}));
		repeat (4)
			send_cmd(rx_frame(ST_RX_OK, 11'($urandom), 4'd8, 1'b1, {$urandom, $urandom}));
		// five bytes free: a two-byte frame just misses, a one-byte frame fits
		send_cmd(rx_frame(ST_RX_OK, 11'($urandom), 4'd2, 1'b1, {$urandom, $urandom}));
		send_cmd(rx_frame(ST_RX_OK, 11'($urandom), 4'd1, 1'b1, {$urandom, $urandom}));
		c = blank_cmd(MODE_EVENT);
		c.status = ST_UNDEFINED;
		send_cmd(c);
		foreach (err_codes[i]) begin
			c.status = err_codes[i];
			send_cmd(c);
		end
		c = blank_cmd(MODE_QUERY);
		c.sel = CNT_SUM;
		send_cmd(c);
		c.sel = SEL_OUT_OF_RANGE;
		send_cmd(c);
		drain_results();

		read_pct = 25;
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 12 : (phase == 1) ? 83 : 0;
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				// swing the queue between filling and draining
				if (k % 60 == 0) begin
					case ($urandom_range(0, 2))
						0:       read_pct = 5;
						1:       read_pct = 25;
						default: read_pct = 45;
					endcase
				end
				send_cmd(random_cmd(read_pct));
				if (k % 100 == 99)
					drain_results();
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
